/* rtl/fim_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fim_pkg
// Shared types, constants and coding functions of the FEC interleave mapper.
// ----------------------------------------------------------------------------
package fim_pkg;

   localparam int MAX_ROWS   = 12;
   localparam int ROW_CNT_W  = 4;   // holds 0..MAX_ROWS
   localparam int ROW_W      = 8;
   localparam int NIBBLE_W   = 4;
   localparam int SYMBOL_W   = 12;
   localparam int WORD_IDX_W = 3;   // word index 0..7
   localparam int WORD_CNT_W = 4;   // word count 5..8

   localparam int SF_W   = 4;
   localparam int CR_W   = 3;
   localparam int CSR_ADDR_W = 2;

   localparam logic [SF_W-1:0] SF_MIN   = 4'd7;
   localparam logic [SF_W-1:0] SF_MAX   = 4'd12;
   localparam logic [SF_W-1:0] SF_RESET = 4'd7;
   localparam logic [CR_W-1:0] CR_MIN   = 3'd1;
   localparam logic [CR_W-1:0] CR_MAX   = 3'd4;
   localparam logic [CR_W-1:0] CR_RESET = 3'd1;
   localparam logic [CR_W-1:0] CR_PARITY = 3'd1;
   localparam logic [CR_W-1:0] CR_SIX    = 3'd2;
   localparam logic [CR_W-1:0] CR_SEVEN  = 3'd3;
   localparam logic [CR_W-1:0] CR_HEADER = 3'd4;

   localparam logic [ROW_W-1:0] MASK_SIX    = 8'h3F;
   localparam logic [ROW_W-1:0] MASK_SEVEN  = 8'h7F;
   localparam logic [ROW_W-1:0] MASK_NIBBLE = 8'h0F;

   localparam logic [WORD_CNT_W-1:0] HEADER_WORDS = 4'd8;
   localparam logic [WORD_CNT_W-1:0] BASE_WORDS   = 4'd4;

   localparam logic [CSR_ADDR_W-1:0] CSR_SF  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CR  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LDR = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                  write_row;
      logic                  emit;
      logic                  last;
      logic [WORD_IDX_W-1:0] word;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic                  block_full;
      logic [WORD_CNT_W-1:0] num_words;
   } status_type;

   function automatic logic [SF_W-1:0] eff_sf(input logic [SF_W-1:0] sf);
      logic [SF_W-1:0] r;
      r = sf;
      if (sf < SF_MIN) r = SF_MIN;
      if (sf > SF_MAX) r = SF_MAX;
      return r;
   endfunction

   function automatic logic [CR_W-1:0] eff_cr(input logic [CR_W-1:0] cr);
      logic [CR_W-1:0] r;
      r = cr;
      if (cr < CR_MIN) r = CR_MIN;
      if (cr > CR_MAX) r = CR_MAX;
      return r;
   endfunction

   // Rows of a block; never more than MAX_ROWS since the spreading factor is
   // saturated at twelve.
   function automatic logic [ROW_CNT_W-1:0] block_rows(input logic hdr, input logic ldr,
                                                      input logic [SF_W-1:0] sf_eff);
      logic [ROW_CNT_W-1:0] r;
      r = (hdr || ldr) ? ROW_CNT_W'(sf_eff - 4'd2) : ROW_CNT_W'(sf_eff);
      return r;
   endfunction

   function automatic logic [ROW_W-1:0] code_row(input logic [NIBBLE_W-1:0] nib,
                                                 input logic [CR_W-1:0] rate);
      logic a, b, c, d;
      logic [ROW_W-1:0] w;
      a = nib[0];
      b = nib[1];
      c = nib[2];
      d = nib[3];
      w = {a ^ c ^ d, a ^ b ^ d, b ^ c ^ d, a ^ b ^ c, nib};
      unique case (rate)
         CR_PARITY: w = (w & MASK_NIBBLE) | {3'b000, a ^ b ^ c ^ d, 4'b0000};
         CR_SIX:    w = w & MASK_SIX;
         CR_SEVEN:  w = w & MASK_SEVEN;
         default:   w = w;
      endcase
      return w;
   endfunction

   function automatic logic [SYMBOL_W-1:0] gray_to_bin(input logic [SYMBOL_W-1:0] g);
      logic [SYMBOL_W-1:0] r;
      r = g;
      r = r ^ (r >> 1);
      r = r ^ (r >> 2);
      r = r ^ (r >> 4);
      r = r ^ (r >> 8);
      return r;
   endfunction

endpackage

/* rtl/fim_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fim_ctrl
// Controller: fills a block row by row, then steps out its symbols.
// ----------------------------------------------------------------------------
module fim_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  fim_pkg::status_type  status,
   output fim_pkg::cmd_type     cmd
);

   typedef enum logic {
      ST_FILL,
      ST_EMIT
   } state_type;

   state_type                           state_ff, state_in;
   logic                                valid_ff, valid_in;
   logic [fim_pkg::WORD_IDX_W-1:0]      word_ff, word_in;
   logic                                load;
   logic                                last_word;

   assign req_tready = (state_ff == ST_FILL);
   assign rsp_tvalid = valid_ff;

   // The output register can take a new symbol when it is empty or its
   // transaction completes in this cycle.
   assign load      = (state_ff == ST_EMIT) && (!valid_ff || rsp_tready);
   assign last_word = ({1'b0, word_ff} == (status.num_words - 4'd1));

   always_comb begin
      cmd.write_row = req_tvalid && req_tready;
      cmd.emit      = load;
      cmd.last      = last_word;
      cmd.word      = word_ff;
   end

   always_comb begin
      state_in = state_ff;
      word_in  = word_ff;
      valid_in = valid_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_FILL: begin
            if (cmd.write_row && status.block_full) begin
               state_in = ST_EMIT;
               word_in  = '0;
            end
         end
         ST_EMIT: begin
            if (load) begin
               valid_in = 1'b1;
               word_in  = word_ff + 3'd1;
               if (last_word) begin
                  state_in = ST_FILL;
               end
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         valid_ff <= 1'b0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         word_ff  <= word_in;
      end
   end

endmodule

/* rtl/fim_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fim_datapath
// Datapath: control registers, row store, diagonal read-out and mapping.
// ----------------------------------------------------------------------------
module fim_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [fim_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [3:0]                        csr_wdata,
   input  logic [fim_pkg::NIBBLE_W-1:0]      nibble,
   input  logic                              header_block,
   input  fim_pkg::cmd_type                  cmd,
   output fim_pkg::status_type               status,
   output logic [fim_pkg::SYMBOL_W-1:0]      symbol,
   output logic                              last
);

   logic [fim_pkg::SF_W-1:0]       sf_ff;
   logic [fim_pkg::CR_W-1:0]       cr_ff;
   logic                           ldr_ff;

   logic [fim_pkg::ROW_W-1:0]      store_ff [fim_pkg::MAX_ROWS];
   logic [fim_pkg::ROW_CNT_W-1:0]  count_ff, count_in;
   logic                           hdr_ff, hdr_in;

   logic [fim_pkg::SF_W-1:0]       sf_eff;
   logic [fim_pkg::CR_W-1:0]       cr_eff;
   logic [fim_pkg::ROW_CNT_W-1:0]  rows_fill, rows_emit;
   logic [fim_pkg::ROW_CNT_W-1:0]  count_next;
   logic [fim_pkg::CR_W-1:0]       row_rate;
   logic [fim_pkg::ROW_W-1:0]      row_code;
   logic                           row_fits;

   logic [fim_pkg::SYMBOL_W-1:0]   column;
   logic [fim_pkg::SYMBOL_W-1:0]   binary;
   logic [fim_pkg::SYMBOL_W-1:0]   shifted;
   logic [fim_pkg::SYMBOL_W-1:0]   sym_mask;
   logic [fim_pkg::SYMBOL_W-1:0]   symbol_in;
   logic [fim_pkg::SYMBOL_W-1:0]   symbol_ff;
   logic                           last_ff;

   assign sf_eff = fim_pkg::eff_sf(sf_ff);
   assign cr_eff = fim_pkg::eff_cr(cr_ff);

   // The block kind is taken from the first nibble of each block.
   assign hdr_in     = (count_ff == '0) ? header_block : hdr_ff;
   assign rows_fill  = fim_pkg::block_rows(hdr_in, ldr_ff, sf_eff);
   assign rows_emit  = fim_pkg::block_rows(hdr_ff, ldr_ff, sf_eff);
   assign row_fits   = (count_ff < 4'(fim_pkg::MAX_ROWS));
   assign count_next = row_fits ? count_ff + 4'd1 : count_ff;
   assign row_rate   = hdr_in ? fim_pkg::CR_HEADER : cr_eff;
   assign row_code   = fim_pkg::code_row(nibble, row_rate);

   assign status.block_full = (count_next >= rows_fill);
   assign status.num_words  = hdr_ff ? fim_pkg::HEADER_WORDS
                                     : fim_pkg::BASE_WORDS + {1'b0, cr_eff};

   always_comb begin
      count_in = count_ff;
      if (cmd.write_row) begin
         count_in = status.block_full ? '0 : count_next;
      end
   end

   // Rows are rotated by one after each word, so word k always reads bit k
   // of rows 0..rows-1 in place.
   always_comb begin
      for (int m = 0; m < fim_pkg::SYMBOL_W; m++) begin
         column[m] = 1'b0;
         if (m < fim_pkg::MAX_ROWS) begin
            column[m] = (4'(m) < rows_emit) ? store_ff[m][cmd.word] : 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < fim_pkg::SYMBOL_W; i++) begin
         sym_mask[i] = (4'(i) < sf_eff);
      end
   end

   assign binary    = fim_pkg::gray_to_bin(column);
   assign shifted   = (hdr_ff || ldr_ff) ? {binary[fim_pkg::SYMBOL_W-3:0], 2'b00} : binary;
   assign symbol_in = (shifted + 12'd1) & sym_mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         sf_ff    <= fim_pkg::SF_RESET;
         cr_ff    <= fim_pkg::CR_RESET;
         ldr_ff   <= 1'b0;
         count_ff <= '0;
         hdr_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_addr)
               fim_pkg::CSR_SF:  sf_ff  <= csr_wdata;
               fim_pkg::CSR_CR:  cr_ff  <= csr_wdata[fim_pkg::CR_W-1:0];
               fim_pkg::CSR_LDR: ldr_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         count_ff <= count_in;
         if (cmd.write_row) begin
            hdr_ff <= hdr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_row && row_fits) begin
         store_ff[count_ff] <= row_code;
      end else if (cmd.emit) begin
         for (int i = 0; i < fim_pkg::MAX_ROWS; i++) begin
            store_ff[i] <= (4'(i) == rows_emit - 4'd1) ? store_ff[0]
                                                      : store_ff[(i + 1) % fim_pkg::MAX_ROWS];
         end
      end
      if (cmd.emit) begin
         symbol_ff <= symbol_in;
         last_ff   <= cmd.last;
      end
   end

   assign symbol = symbol_ff;
   assign last   = last_ff;

endmodule

/* rtl/css_block_fec_interleave_mapper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_block_fec_interleave_mapper
// Hamming coder, diagonal block interleaver and chirp symbol mapper.
// ----------------------------------------------------------------------------
// Nibbles are taken only while no block is emitting; a block of R rows (R = sf or
// sf-2) then emits W symbols (W = cr+4, or 8 for a header) from the output
// register, one per cycle while the receiver does not stall. The controller
// enters its emit state once the last nibble is taken, then loads the first symbol;
// a new block's first nibble is taken while the previous last symbol still waits.
// Synchronous reset clears the control state and restores sf 7, cr 1, ldr 0.
module css_block_fec_interleave_mapper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] nibble, [7:4] zero
   input  logic [0:0]  req_tuser,   // [0] header_block
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] symbol, [15:12] zero
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_addr,
   input  logic [3:0]  csr_wdata
);

   fim_pkg::cmd_type                 cmd;
   fim_pkg::status_type              status;
   logic [fim_pkg::SYMBOL_W-1:0]     symbol;
   logic                             last;

   assign csr_ready = 1'b1;

   fim_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fim_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .nibble       (req_tdata[fim_pkg::NIBBLE_W-1:0]),
      .header_block (req_tuser[0]),
      .cmd          (cmd),
      .status       (status),
      .symbol       (symbol),
      .last         (last)
   );

   assign rsp_tdata = {4'b0000, symbol};
   assign rsp_tlast = last;

endmodule

/* test/css_block_fec_interleave_mapper_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_block_fec_interleave_mapper_test
// Self-checking bench for the Hamming coder, diagonal interleaver and symbol
// mapper. A scoreboard predicts the symbols of every completed block from the
// accepted nibbles and the register settings, and checks each symbol that
// leaves the block. Directed blocks come first, then random blocks under
// several register settings and with random idling on both streams.
// ----------------------------------------------------------------------------
module css_block_fec_interleave_mapper_test;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 32;
   localparam int HOLD_CYCLES   = 400;
   localparam int SUB_PHASES    = 8;
   localparam int PHASE_ITEMS   = 24;

   // Address 3 decodes to no register.
   localparam logic [fim_pkg::CSR_ADDR_W-1:0] CSR_NONE = 2'd3;

   typedef struct packed {
      logic [fim_pkg::SYMBOL_W-1:0] symbol;
      logic                         last;
   } symbol_item_type;

   class symbol_scoreboard;
      logic [fim_pkg::SF_W-1:0]  sf_reg;
      logic [fim_pkg::CR_W-1:0]  cr_reg;
      logic                      ldr_reg;
      logic [fim_pkg::ROW_W-1:0] block_rows_q [fim_pkg::MAX_ROWS];
      int unsigned               held;
      logic                      hdr_blk;
      symbol_item_type           expected_q [$];
      int                        errors;

      function new();
         sf_reg  = fim_pkg::SF_RESET;
         cr_reg  = fim_pkg::CR_RESET;
         ldr_reg = 1'b0;
         held    = 0;
         hdr_blk = 1'b0;
         errors  = 0;
         foreach (block_rows_q[i]) block_rows_q[i] = '0;
      endfunction

      function void write_reg(logic [fim_pkg::CSR_ADDR_W-1:0] addr, logic [3:0] data);
         case (addr)
            fim_pkg::CSR_SF:  sf_reg  = data;
            fim_pkg::CSR_CR:  cr_reg  = data[fim_pkg::CR_W-1:0];
            fim_pkg::CSR_LDR: ldr_reg = data[0];
            default: ;
         endcase
      endfunction

      function int unsigned active_sf();
         if (sf_reg < fim_pkg::SF_MIN) return fim_pkg::SF_MIN;
         if (sf_reg > fim_pkg::SF_MAX) return fim_pkg::SF_MAX;
         return sf_reg;
      endfunction

      function int unsigned active_cr();
         if (cr_reg < fim_pkg::CR_MIN) return fim_pkg::CR_MIN;
         if (cr_reg > fim_pkg::CR_MAX) return fim_pkg::CR_MAX;
         return cr_reg;
      endfunction

      function int unsigned span(logic hdr);
         int unsigned n;
         n = (hdr || ldr_reg) ? active_sf() - 2 : active_sf();
         if (n > fim_pkg::MAX_ROWS) n = fim_pkg::MAX_ROWS;
         return n;
      endfunction

      function logic [fim_pkg::ROW_W-1:0] encode(logic [fim_pkg::NIBBLE_W-1:0] nib,
                                                 int unsigned rate);
         logic [fim_pkg::ROW_W-1:0] cw;
         cw[3:0] = nib;
         cw[4]   = nib[0] ^ nib[1] ^ nib[2];
         cw[5]   = nib[1] ^ nib[2] ^ nib[3];
         cw[6]   = nib[0] ^ nib[1] ^ nib[3];
         cw[7]   = nib[0] ^ nib[2] ^ nib[3];
         if (rate == fim_pkg::CR_PARITY) cw = {3'b000, ^nib, nib};
         else if (rate == fim_pkg::CR_SIX) cw = cw & fim_pkg::MASK_SIX;
         else if (rate == fim_pkg::CR_SEVEN) cw = cw & fim_pkg::MASK_SEVEN;
         return cw;
      endfunction

      function int unsigned ungray(int unsigned g);
         int unsigned acc;
         acc = 0;
         for (int i = 0; i < fim_pkg::SYMBOL_W; i++) acc ^= g >> i;
         return acc;
      endfunction

      // Nibbles still needed to close the current block; hdr only matters
      // when no row is held yet.
      function int unsigned rows_needed(logic hdr);
         int unsigned n;
         n = span(held == 0 ? hdr : hdr_blk);
         return (held >= n) ? 1 : n - held;
      endfunction

      function void note_nibble(logic [fim_pkg::NIBBLE_W-1:0] nib, logic hdr);
         int unsigned rows, words, shift, mask, w, v;
         symbol_item_type item;
         if (held == 0) hdr_blk = hdr;
         rows = span(hdr_blk);
         if (held < fim_pkg::MAX_ROWS) begin
            block_rows_q[held] = encode(nib, hdr_blk ? fim_pkg::CR_HEADER : active_cr());
            held++;
         end
         if (held < rows) return;
         mask  = (1 << active_sf()) - 1;
         words = hdr_blk ? fim_pkg::HEADER_WORDS : active_cr() + fim_pkg::BASE_WORDS;
         shift = (hdr_blk || ldr_reg) ? 2 : 0;
         // Word k takes bit k of the rows, walking the block diagonally.
         for (int k = 0; k < words; k++) begin
            w = 0;
            for (int m = 0; m < rows; m++)
               w |= ((block_rows_q[(m + k) % rows] >> k) & 1) << m;
            v = ((ungray(w) << shift) + 1) & mask;
            item.symbol = v[fim_pkg::SYMBOL_W-1:0];
            item.last   = (k + 1 == words);
            expected_q = {expected_q, item};
         end
         held = 0;
      endfunction

      function void check_symbol(logic [15:0] data, logic tlast);
         symbol_item_type exp_item;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected symbol %h last %b", $time, data, tlast);
            errors++;
            return;
         end
         exp_item = expected_q.pop_front();
         if (data !== {4'b0000, exp_item.symbol}) begin
            $display("%0t: symbol mismatch: expected %h, actual %h",
                     $time, exp_item.symbol, data);
            errors++;
         end
         if (tlast !== exp_item.last) begin
            $display("%0t: last flag mismatch: expected %b, actual %b",
                     $time, exp_item.last, tlast);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [3:0] nibble, [7:4] zero
   logic [0:0]  req_tuser = '0;    // [0] header_block
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [11:0] symbol, [15:12] zero
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_addr = '0;
   logic [3:0]  csr_wdata = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_len      = 0;
   int hold_left     = 0;

   symbol_scoreboard sb;

   css_block_fec_interleave_mapper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Receiver: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_len > 0) begin
         hold_left = hold_len;
         hold_len  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_symbol(rsp_tdata, rsp_tlast);
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   // Leaves tvalid high so that the next transaction can follow back to back.
   task automatic send_nibble(input logic [fim_pkg::NIBBLE_W-1:0] nib, input logic hdr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, nib};
      req_tuser  <= hdr;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_nibble(nib, hdr);
   endtask

   task automatic write_csr(input logic [fim_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [3:0] data);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(addr, data);
   endtask

   // A nibble that closes no block leaves nothing to wait for, so a settling
   // wait follows the last expected symbol.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned n;
      logic        hdr;
      logic [3:0]  sf_w, cr_w, ldr_w;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Header block at the reset settings, then a rate 4/5 payload block.
      send_nibble(4'hF, 1'b1);
      send_nibble(4'h0, 1'b0);
      send_nibble(4'hA, 1'b1);
      send_nibble(4'h5, 1'b0);
      send_nibble(4'hF, 1'b1);
      send_nibble(4'h0, 1'b0);
      send_nibble(4'hF, 1'b1);
      send_nibble(4'h1, 1'b0);
      send_nibble(4'h2, 1'b1);
      send_nibble(4'h4, 1'b0);
      send_nibble(4'h8, 1'b1);
      send_nibble(4'h7, 1'b0);
      settle();

      // Out-of-range spreading factor and coding rate saturate; the unused
      // address changes nothing.
      write_csr(fim_pkg::CSR_SF, 4'd3);
      write_csr(fim_pkg::CSR_CR, 4'hF);
      write_csr(fim_pkg::CSR_LDR, 4'hF);
      write_csr(CSR_NONE, 4'hA);
      csr_valid <= 1'b0;
      send_nibble(4'hF, 1'b0);
      send_nibble(4'hE, 1'b1);
      send_nibble(4'hD, 1'b0);
      send_nibble(4'h0, 1'b1);
      send_nibble(4'h3, 1'b0);
      settle();

      // The row count shrinks while a block is half full.
      write_csr(fim_pkg::CSR_SF, 4'd12);
      write_csr(fim_pkg::CSR_CR, 4'd2);
      write_csr(fim_pkg::CSR_LDR, 4'hE);
      csr_valid <= 1'b0;
      for (int i = 0; i < 6; i++) send_nibble(4'(i * 3), 1'b0);
      settle();
      write_csr(fim_pkg::CSR_SF, 4'd8);
      csr_valid <= 1'b0;
      send_nibble(4'hC, 1'b1);
      send_nibble(4'h9, 1'b0);
      settle();

      for (int sub = 0; sub < SUB_PHASES; sub++) begin
         if (sub == 0) begin
            sf_w = 4'd7;
            cr_w = 4'd1;
            ldr_w = 4'd0;
         end else if (sub == 1) begin
            sf_w = 4'd12;
            cr_w = 4'd4;
            ldr_w = 4'd1;
         end else begin
            sf_w = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                            : 4'($urandom_range(12, 7));
            cr_w = ($urandom_range(9) == 0) ? 4'($urandom_range(7))
                                            : 4'($urandom_range(4, 1));
            cr_w[3] = 1'($urandom_range(1));
            ldr_w = 4'($urandom_range(15));
         end
         write_csr(fim_pkg::CSR_SF, sf_w);
         write_csr(fim_pkg::CSR_CR, cr_w);
         write_csr(fim_pkg::CSR_LDR, ldr_w);
         csr_valid <= 1'b0;

         case (sub % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
         endcase
         // Long receiver hold-off so the block backs up into its input.
         if (sub == 4) hold_len = HOLD_CYCLES;

         n = 0;
         while (n < PHASE_ITEMS) begin
            int unsigned count;
            hdr = ($urandom_range(3) == 0);
            // Mostly whole blocks; now and then a short burst that breaks
            // the block alignment.
            count = ($urandom_range(99) < 15) ? $urandom_range(3, 1) : sb.rows_needed(hdr);
            for (int j = 0; j < count; j++) begin
               send_nibble(4'($urandom_range(15)), j == 0 ? hdr : 1'($urandom_range(1)));
               n++;
            end
         end
         settle();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
